>>> design/rotation_phase_tracker_assert.svh
// ----------------------------------------------------------------------------
// Rotation phase tracker assertion macros
// Shorthand for clocked implication checks, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ROTATION_PHASE_TRACKER_ASSERT_SVH
`define ROTATION_PHASE_TRACKER_ASSERT_SVH

// same-cycle implication
`define RPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/rpt_pkg.sv
// ----------------------------------------------------------------------------
// Rotation phase tracker package
// Widths, reset values and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package rpt_pkg;

  localparam int TS_W             = 32;
  localparam int PHASE_W          = 30;
  localparam int STEP_W           = 32;
  localparam int DIVIDEND_W       = PHASE_W + 1;
  localparam int CNT_W            = $clog2(DIVIDEND_W);
  localparam int HISTORY_DEPTH    = 8;
  localparam int RING_IDX_W       = $clog2(HISTORY_DEPTH);
  localparam int MID_LO           = HISTORY_DEPTH / 2 - 1;
  localparam int MID_HI           = HISTORY_DEPTH / 2;
  localparam int NUM_SLICES_DEF   = 100;
  localparam int ANGLE_TOP_W      = 10;
  localparam int SLICE_SCALE_W    = 10;
  localparam int CFG_INDEX_W      = 2;
  localparam int CFG_DATA_W       = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_PERIOD = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_DRIFT_RATE = CFG_INDEX_W'(1);

  localparam logic [TS_W-1:0]    MIN_PERIOD_RESET = TS_W'(10000);
  localparam logic [STEP_W-1:0]  STEP_RESET       = STEP_W'(256);
  localparam logic [PHASE_W-1:0] ZERO_RESET       =
    PHASE_W'(((64'd1 << PHASE_W) / 64'd360) * 64'd286);
  localparam logic [DIVIDEND_W-1:0] DIVIDEND      = DIVIDEND_W'(1) << PHASE_W;

  typedef struct packed {
    logic capture;
    logic edge_upd;
    logic sort_load;
    logic sort_pass;
    logic sort_odd;
    logic median;
    logic div_step;
    logic step_load;
    logic mul;
    logic acc;
    logic angle_upd;
    logic out_load;
  } rpt_cmd_t;

  typedef struct packed {
    logic take;
    logic med_zero;
  } rpt_status_t;

endpackage

>>> design/rpt_ctrl.sv
// ----------------------------------------------------------------------------
// Rotation phase tracker controller
// Sequences edge bookkeeping, median sort, step divide and accumulation.
// ----------------------------------------------------------------------------
module rpt_ctrl
  import rpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  rpt_status_t status,
  output rpt_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EDGE   = 4'd1;
  localparam logic [3:0] S_SLOAD  = 4'd2;
  localparam logic [3:0] S_SORT   = 4'd3;
  localparam logic [3:0] S_MED    = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_DSTORE = 4'd6;
  localparam logic [3:0] S_MUL    = 4'd7;
  localparam logic [3:0] S_ACC    = 4'd8;
  localparam logic [3:0] S_ANGLE  = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  localparam logic [CNT_W-1:0] SORT_LAST = CNT_W'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIVIDEND_W - 1);

  logic [3:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EDGE;
        end
      end
      S_EDGE: begin
        cmd.edge_upd = 1'b1;
        state_next   = status.take ? S_SLOAD : S_MUL;
      end
      S_SLOAD: begin
        cmd.sort_load = 1'b1;
        cnt_next      = '0;
        state_next    = S_SORT;
      end
      S_SORT: begin
        cmd.sort_pass = 1'b1;
        cmd.sort_odd  = cnt[0];
        cnt_next      = cnt + 1'b1;
        if (cnt == SORT_LAST) begin
          state_next = S_MED;
        end
      end
      S_MED: begin
        cmd.median = 1'b1;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (status.med_zero) begin
          state_next = S_MUL;
        end else begin
          cmd.div_step = 1'b1;
          cnt_next     = cnt + 1'b1;
          if (cnt == DIV_LAST) begin
            state_next = S_DSTORE;
          end
        end
      end
      S_DSTORE: begin
        cmd.step_load = 1'b1;
        state_next    = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_ANGLE;
      end
      S_ANGLE: begin
        cmd.angle_upd = 1'b1;
        state_next    = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `include "rotation_phase_tracker_assert.svh"

  `RPT_ASSERT_NEXT(a_out_hold, state == S_OUT && out_valid && out_stall, state == S_OUT, "result overwritten while stalled")
  `RPT_ASSERT_NOW(a_div_count, state == S_DIV, cnt <= DIV_LAST, "divide count out of range")
  `RPT_ASSERT_NOW(a_out_source, $rose(out_valid), $past(state) == S_OUT, "result shown without load")

endmodule

>>> design/rpt_datapath.sv
// ----------------------------------------------------------------------------
// Rotation phase tracker datapath
// Period ring, transposition sorter, restoring divider, phase accumulators.
// ----------------------------------------------------------------------------
module rpt_datapath
  import rpt_pkg::*;
#(
  parameter int  NUM_SLICES = NUM_SLICES_DEF,
  localparam int SLICE_W    = $clog2(NUM_SLICES)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [TS_W-1:0]        timestamp_us,
  input  logic                   sync_in,
  input  rpt_cmd_t               cmd,
  output rpt_status_t            status,
  output logic [PHASE_W-1:0]     angle,
  output logic [SLICE_W-1:0]     slice_index
);

  localparam int SC_W   = $clog2(NUM_SLICES + 1);
  localparam int PROD_W = ANGLE_TOP_W + SC_W;

  logic [TS_W-1:0]        min_period_us;
  logic signed [TS_W-1:0] drift_rate;

  logic [TS_W-1:0]       ts;
  logic                  sync;
  logic [TS_W-1:0]       last_edge_time;
  logic [TS_W-1:0]       last_sample_time;
  logic                  prior_sync_level;
  logic [TS_W-1:0]       period_ring [HISTORY_DEPTH];
  logic [RING_IDX_W-1:0] ring_slot;
  logic [RING_IDX_W-1:0] ring_slot_next;
  logic [TS_W-1:0]       sort_v [HISTORY_DEPTH];
  logic [TS_W-1:0]       sort_next [HISTORY_DEPTH];
  logic [TS_W-1:0]       med;
  logic [TS_W:0]         med_sum;
  logic [TS_W-1:0]       rem;
  logic [DIVIDEND_W-1:0] quo;
  logic [TS_W:0]         trial;
  logic                  trial_ok;
  logic [STEP_W-1:0]     phase_step;
  logic [TS_W-1:0]       dtick;
  logic [TS_W-1:0]       elapsed;
  logic [TS_W-1:0]       mul_phase;
  logic [TS_W-1:0]       mul_drift;
  logic [PHASE_W-1:0]    phase_prod;
  logic [PHASE_W-1:0]    drift_prod;
  logic [PHASE_W-1:0]    phase_accum;
  logic [PHASE_W-1:0]    zero_offset;
  logic [PHASE_W-1:0]    angle_sum;
  logic [PROD_W-1:0]     slice_prod;

  assign elapsed         = ts - last_edge_time;
  assign ring_slot_next  = ring_slot + 1'b1;
  assign status.take     = (sync != prior_sync_level) && !sync && (elapsed > min_period_us);
  assign status.med_zero = (med == '0);

  assign med_sum  = {1'b0, sort_v[MID_LO]} + {1'b0, sort_v[MID_HI]};
  assign trial    = {rem, quo[DIVIDEND_W-1]};
  assign trial_ok = (trial >= {1'b0, med});

  assign mul_phase  = dtick * phase_step;
  assign mul_drift  = dtick * $unsigned(drift_rate);
  assign slice_prod = angle_sum[PHASE_W-1 -: ANGLE_TOP_W] * PROD_W'(NUM_SLICES);

  always_comb begin
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      sort_next[i] = sort_v[i];
    end
    for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
      if ((i[0] == cmd.sort_odd) && (sort_v[i] > sort_v[i+1])) begin
        sort_next[i]   = sort_v[i+1];
        sort_next[i+1] = sort_v[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_period_us <= MIN_PERIOD_RESET;
      drift_rate    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MIN_PERIOD: min_period_us <= cfg_data;
        CFG_DRIFT_RATE: drift_rate    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time   <= '0;
      last_sample_time <= '0;
      prior_sync_level <= 1'b1;
      ring_slot        <= '0;
      phase_step       <= STEP_RESET;
      phase_accum      <= '0;
      zero_offset      <= ZERO_RESET;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        period_ring[i] <= '0;
      end
    end else begin
      if (cmd.edge_upd) begin
        last_sample_time <= ts;
        if (sync != prior_sync_level) begin
          prior_sync_level <= sync;
          if (!sync) begin
            last_edge_time <= ts;
          end
        end
        if (status.take) begin
          ring_slot                   <= ring_slot_next;
          period_ring[ring_slot_next] <= elapsed;
        end
      end
      if (cmd.step_load) begin
        phase_step <= STEP_W'(quo);
      end
      if (cmd.acc) begin
        phase_accum <= phase_accum + phase_prod;
        zero_offset <= zero_offset + drift_prod;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ts   <= timestamp_us;
      sync <= sync_in;
    end
    if (cmd.edge_upd) begin
      dtick <= ts - last_sample_time;
    end
    if (cmd.sort_load) begin
      sort_v <= period_ring;
    end else if (cmd.sort_pass) begin
      sort_v <= sort_next;
    end
    if (cmd.median) begin
      med <= med_sum[TS_W:1];
      rem <= '0;
      quo <= DIVIDEND;
    end else if (cmd.div_step) begin
      rem <= trial_ok ? TS_W'(trial - {1'b0, med}) : trial[TS_W-1:0];
      quo <= {quo[DIVIDEND_W-2:0], trial_ok};
    end
    if (cmd.mul) begin
      phase_prod <= mul_phase[PHASE_W-1:0];
      drift_prod <= mul_drift[PHASE_W-1:0];
    end
    if (cmd.angle_upd) begin
      angle_sum <= phase_accum + zero_offset;
    end
    if (cmd.out_load) begin
      angle       <= angle_sum;
      slice_index <= slice_prod[SLICE_SCALE_W +: SLICE_W];
    end
  end

endmodule

>>> design/rotation_phase_tracker.sv
// ----------------------------------------------------------------------------
// Rotation phase tracker
// Angle of a spinning display from a once-per-turn sync, with slice index.
//
//   channel  handshake             payload
//   in       in_valid / in_stall   timestamp_us, sync_in
//   out      out_valid / out_stall angle, slice_index
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A sample without a qualifying falling edge goes from accept through the edge,
// multiply, accumulate, angle and output states; one that enters the period ring
// also takes 8 sort passes on the transposition sorter and 31 restoring divide
// steps, and skips the divide when the median is zero.
// rst is synchronous; it restores the step, offsets and clears the ring.
// A stalled result holds; the next sample is taken while it waits.
// ----------------------------------------------------------------------------
module rotation_phase_tracker
  import rpt_pkg::*;
#(
  parameter int  NUM_SLICES = NUM_SLICES_DEF,
  localparam int SLICE_W    = $clog2(NUM_SLICES)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [TS_W-1:0]        timestamp_us,
  input  logic                   sync_in,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [PHASE_W-1:0]     angle,
  output logic [SLICE_W-1:0]     slice_index
);

  rpt_cmd_t    cmd;
  rpt_status_t status;

  assign cfg_ready = 1'b1;

  rpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  rpt_datapath #(
    .NUM_SLICES (NUM_SLICES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .timestamp_us (timestamp_us),
    .sync_in      (sync_in),
    .cmd          (cmd),
    .status       (status),
    .angle        (angle),
    .slice_index  (slice_index)
  );

endmodule
